/* rtl/psd_pkg.sv */
// psd_pkg: types and constants for the point to segment distance block.
// No dependencies; used by every file in rtl/.

package psd_pkg;

  localparam int unsigned CoordW  = 16;            // coordinate width, 4 fractional bits
  localparam int unsigned VecW    = CoordW + 1;    // difference of two coordinates
  localparam int unsigned LenW    = 2 * CoordW + 2; // squared length
  localparam int unsigned DotW    = 2 * CoordW + 3; // signed dot product
  localparam int unsigned TFracW  = 16;            // fractional bits of t
  localparam int unsigned TW      = TFracW + 1;    // t including the 1.0 code
  localparam int unsigned DistW   = 17;
  localparam int unsigned CfgW    = 16;
  localparam logic [CfgW-1:0] CfgResetVal = CfgW'(1);
  localparam logic [DistW-1:0] DistMax    = {DistW{1'b1}};
  localparam logic [TW-1:0]    TOne       = TW'(1) << TFracW;

  typedef enum logic [1:0] {
    REG_DEGEN    = 2'd0,
    REG_START    = 2'd1,
    REG_INTERIOR = 2'd2,
    REG_END      = 2'd3
  } psd_region_e;

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] end_y;
  } psd_in_t;

  typedef struct packed {
    logic [DistW-1:0] distance;
    logic [TW-1:0]    param_t;
    psd_region_e      region;
  } psd_out_t;

  // classified job handed from front to back
  typedef struct packed {
    logic signed [CoordW-1:0] p_x;
    logic signed [CoordW-1:0] p_y;
    logic signed [CoordW-1:0] a_x;
    logic signed [CoordW-1:0] a_y;
    logic signed [VecW-1:0]   v_x;
    logic signed [VecW-1:0]   v_y;
    logic [LenW-1:0]          len_sq;
    logic [LenW-1:0]          dot;
    psd_region_e              region;
  } psd_job_t;

endpackage

/* rtl/psd_front.sv */
// psd_front: three stage front end, forms segment vector, squared length and
// dot product, classifies the region. Holds the threshold register. Uses psd_pkg.

module psd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  psd_pkg::psd_in_t  in_word_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [psd_pkg::CfgW-1:0] cfg_data_i,
  input  logic              full_i,
  output logic              push_o,
  output psd_pkg::psd_job_t job_o
);

  localparam int unsigned CW = psd_pkg::CoordW;
  localparam int unsigned VW = psd_pkg::VecW;
  localparam int unsigned LW = psd_pkg::LenW;
  localparam int unsigned DW = psd_pkg::DotW;

  logic adv;
  logic [psd_pkg::CfgW-1:0] min_len_q;
  logic s1_valid_q, s2_valid_q, s3_valid_q;

  logic signed [CW-1:0] s1_px_q, s1_py_q, s1_ax_q, s1_ay_q;
  logic signed [VW-1:0] s1_vx_q, s1_vy_q, s1_wx_q, s1_wy_q;
  logic signed [CW-1:0] s2_px_q, s2_py_q, s2_ax_q, s2_ay_q;
  logic signed [VW-1:0] s2_vx_q, s2_vy_q;
  logic signed [LW-1:0] s2_vxx_q, s2_vyy_q, s2_wvx_q, s2_wvy_q;
  logic signed [CW-1:0] s3_px_q, s3_py_q, s3_ax_q, s3_ay_q;
  logic signed [VW-1:0] s3_vx_q, s3_vy_q;
  logic [LW-1:0]        s3_len_q;
  logic signed [DW-1:0] s3_dot_q;
  psd_pkg::psd_region_e region;

  assign adv         = !(s3_valid_q && full_i);
  assign in_stall_o  = !adv;
  assign push_o      = s3_valid_q && !full_i;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= psd_pkg::CfgResetVal;
    end else if (cfg_valid_i) begin
      min_len_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_px_q <= in_word_i.point_x;
      s1_py_q <= in_word_i.point_y;
      s1_ax_q <= in_word_i.start_x;
      s1_ay_q <= in_word_i.start_y;
      s1_vx_q <= VW'(in_word_i.end_x) - VW'(in_word_i.start_x);
      s1_vy_q <= VW'(in_word_i.end_y) - VW'(in_word_i.start_y);
      s1_wx_q <= VW'(in_word_i.point_x) - VW'(in_word_i.start_x);
      s1_wy_q <= VW'(in_word_i.point_y) - VW'(in_word_i.start_y);

      s2_px_q  <= s1_px_q;
      s2_py_q  <= s1_py_q;
      s2_ax_q  <= s1_ax_q;
      s2_ay_q  <= s1_ay_q;
      s2_vx_q  <= s1_vx_q;
      s2_vy_q  <= s1_vy_q;
      s2_vxx_q <= s1_vx_q * s1_vx_q;
      s2_vyy_q <= s1_vy_q * s1_vy_q;
      s2_wvx_q <= s1_wx_q * s1_vx_q;
      s2_wvy_q <= s1_wy_q * s1_vy_q;

      s3_px_q  <= s2_px_q;
      s3_py_q  <= s2_py_q;
      s3_ax_q  <= s2_ax_q;
      s3_ay_q  <= s2_ay_q;
      s3_vx_q  <= s2_vx_q;
      s3_vy_q  <= s2_vy_q;
      s3_len_q <= $unsigned(s2_vxx_q) + $unsigned(s2_vyy_q);
      s3_dot_q <= DW'(s2_wvx_q) + DW'(s2_wvy_q);
    end
  end

  always_comb begin
    if (s3_len_q < LW'(min_len_q)) begin
      region = psd_pkg::REG_DEGEN;
    end else if (s3_dot_q[DW-1] || (s3_dot_q == '0)) begin
      region = psd_pkg::REG_START;
    end else if ($unsigned(s3_dot_q) >= DW'(s3_len_q)) begin
      region = psd_pkg::REG_END;
    end else begin
      region = psd_pkg::REG_INTERIOR;
    end
  end

  always_comb begin
    job_o.p_x    = s3_px_q;
    job_o.p_y    = s3_py_q;
    job_o.a_x    = s3_ax_q;
    job_o.a_y    = s3_ay_q;
    job_o.v_x    = s3_vx_q;
    job_o.v_y    = s3_vy_q;
    job_o.len_sq = s3_len_q;
    job_o.dot    = s3_dot_q[LW-1:0];
    job_o.region = region;
  end

endmodule

/* rtl/psd_queue.sv */
// psd_queue: small FIFO of classified jobs between front and back.
// Uses psd_pkg::psd_job_t.

module psd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  psd_pkg::psd_job_t job_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output psd_pkg::psd_job_t job_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  psd_pkg::psd_job_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

/* rtl/psd_back.sv */
// psd_back: pipelined back end: radix-4 division for t, nearest point,
// squared offset and radix-4 square root, then the output register. Uses psd_pkg.

module psd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  psd_pkg::psd_job_t job_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output psd_pkg::psd_out_t out_word_o
);

  localparam int unsigned CW      = psd_pkg::CoordW;
  localparam int unsigned VW      = psd_pkg::VecW;
  localparam int unsigned LW      = psd_pkg::LenW;
  localparam int unsigned TFW     = psd_pkg::TFracW;
  localparam int unsigned TW      = psd_pkg::TW;
  localparam int unsigned DivStg  = TFW / 2;
  localparam int unsigned PW      = TW + VW + 1;   // t * v product
  localparam int unsigned BW      = PW + 1;        // start scaled plus product
  localparam int unsigned NW      = BW - TFW;      // nearest point
  localparam int unsigned MW      = CW + 1;        // offset magnitude
  localparam int unsigned RadW    = 2 * MW + 2;    // even radicand width
  localparam int unsigned RootW   = RadW / 2;
  localparam int unsigned RemW    = RootW + 2;
  localparam int unsigned SqStg   = RootW / 2 + RootW % 2;

  typedef struct packed {
    logic signed [CW-1:0] p_x;
    logic signed [CW-1:0] p_y;
    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    logic signed [VW-1:0] v_x;
    logic signed [VW-1:0] v_y;
    logic [LW-1:0]        len;
    logic [LW-1:0]        rem;
    logic [TFW-1:0]       quo;
    psd_pkg::psd_region_e region;
  } div_t;

  typedef struct packed {
    logic [RadW-1:0]      rad;
    logic [RemW-1:0]      rem;
    logic [RootW-1:0]     root;
    logic [TW-1:0]        t;
    psd_pkg::psd_region_e region;
  } sqr_t;

  function automatic div_t div_pair(div_t s);
    div_t r;
    logic [LW:0] sh;
    r = s;
    for (int i = 0; i < 2; i++) begin
      sh = {r.rem, 1'b0};
      if (sh >= {1'b0, r.len}) begin
        r.rem = LW'(sh - {1'b0, r.len});
        r.quo = {r.quo[TFW-2:0], 1'b1};
      end else begin
        r.rem = sh[LW-1:0];
        r.quo = {r.quo[TFW-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  function automatic sqr_t sqr_pair(sqr_t s);
    sqr_t r;
    logic [RemW+1:0] rn;
    logic [RemW+1:0] trial;
    r = s;
    for (int i = 0; i < 2; i++) begin
      rn    = {r.rem, r.rad[RadW-1 -: 2]};
      r.rad = {r.rad[RadW-3:0], 2'b00};
      trial = (RemW + 2)'({r.root, 2'b01});
      if (rn >= trial) begin
        r.rem  = RemW'(rn - trial);
        r.root = {r.root[RootW-2:0], 1'b1};
      end else begin
        r.rem  = rn[RemW-1:0];
        r.root = {r.root[RootW-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  logic adv;
  div_t div_q [DivStg+1];
  logic div_v_q [DivStg+1];
  div_t div_ld;

  logic [TW-1:0]        t_d;
  logic signed [PW-1:0] m_prodx_q, m_prody_q;
  logic signed [CW-1:0] m_px_q, m_py_q, m_ax_q, m_ay_q;
  logic [TW-1:0]        m_t_q;
  psd_pkg::psd_region_e m_region_q;
  logic                 m_v_q;

  logic signed [BW-1:0] n_bx, n_by;
  logic signed [NW-1:0] n_dx, n_dy;
  logic [MW-1:0]        n_magx_q, n_magy_q;
  logic [TW-1:0]        n_t_q;
  psd_pkg::psd_region_e n_region_q;
  logic                 n_v_q;

  logic [2*MW-1:0]      s_sqx_q, s_sqy_q;
  logic [TW-1:0]        s_t_q;
  psd_pkg::psd_region_e s_region_q;
  logic                 s_v_q;

  sqr_t sq_q [SqStg+1];
  logic sq_v_q [SqStg+1];

  logic out_valid_q;
  psd_pkg::psd_out_t out_word_q;

  assign adv         = !out_valid_q || !out_stall_i;
  assign pop_o       = adv && !empty_i;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  always_comb begin
    div_ld.p_x    = job_i.p_x;
    div_ld.p_y    = job_i.p_y;
    div_ld.a_x    = job_i.a_x;
    div_ld.a_y    = job_i.a_y;
    div_ld.v_x    = job_i.v_x;
    div_ld.v_y    = job_i.v_y;
    div_ld.len    = job_i.len_sq;
    div_ld.rem    = job_i.dot;
    div_ld.quo    = '0;
    div_ld.region = job_i.region;
  end

  always_comb begin
    case (div_q[DivStg].region)
      psd_pkg::REG_INTERIOR: t_d = {1'b0, div_q[DivStg].quo};
      psd_pkg::REG_END:      t_d = psd_pkg::TOne;
      default:               t_d = '0;
    endcase
  end

  // nearest point = floor((a * 2^f + t * v) / 2^f), then offset to the query point
  always_comb begin
    n_bx = {{(BW - CW - TFW){m_ax_q[CW-1]}}, m_ax_q, {TFW{1'b0}}} + BW'(m_prodx_q);
    n_by = {{(BW - CW - TFW){m_ay_q[CW-1]}}, m_ay_q, {TFW{1'b0}}} + BW'(m_prody_q);
    n_dx = NW'(m_px_q) - n_bx[BW-1:TFW];
    n_dy = NW'(m_py_q) - n_by[BW-1:TFW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= DivStg; k++) div_v_q[k] <= 1'b0;
      for (int k = 0; k <= SqStg; k++)  sq_v_q[k]  <= 1'b0;
      m_v_q       <= 1'b0;
      n_v_q       <= 1'b0;
      s_v_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      div_v_q[0] <= !empty_i;
      for (int k = 0; k < DivStg; k++) div_v_q[k+1] <= div_v_q[k];
      m_v_q     <= div_v_q[DivStg];
      n_v_q     <= m_v_q;
      s_v_q     <= n_v_q;
      sq_v_q[0] <= s_v_q;
      for (int k = 0; k < SqStg; k++) sq_v_q[k+1] <= sq_v_q[k];
      out_valid_q <= sq_v_q[SqStg];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      div_q[0] <= div_ld;
      for (int k = 0; k < DivStg; k++) div_q[k+1] <= div_pair(div_q[k]);

      m_px_q     <= div_q[DivStg].p_x;
      m_py_q     <= div_q[DivStg].p_y;
      m_ax_q     <= div_q[DivStg].a_x;
      m_ay_q     <= div_q[DivStg].a_y;
      m_prodx_q  <= $signed({1'b0, t_d}) * div_q[DivStg].v_x;
      m_prody_q  <= $signed({1'b0, t_d}) * div_q[DivStg].v_y;
      m_t_q      <= t_d;
      m_region_q <= div_q[DivStg].region;

      n_magx_q   <= n_dx[NW-1] ? MW'(-n_dx) : MW'(n_dx);
      n_magy_q   <= n_dy[NW-1] ? MW'(-n_dy) : MW'(n_dy);
      n_t_q      <= m_t_q;
      n_region_q <= m_region_q;

      s_sqx_q    <= n_magx_q * n_magx_q;
      s_sqy_q    <= n_magy_q * n_magy_q;
      s_t_q      <= n_t_q;
      s_region_q <= n_region_q;

      sq_q[0].rad    <= RadW'(s_sqx_q) + RadW'(s_sqy_q);
      sq_q[0].rem    <= '0;
      sq_q[0].root   <= '0;
      sq_q[0].t      <= s_t_q;
      sq_q[0].region <= s_region_q;
      for (int k = 0; k < SqStg; k++) sq_q[k+1] <= sqr_pair(sq_q[k]);

      out_word_q.distance <= (sq_q[SqStg].root > RootW'(psd_pkg::DistMax)) ?
                             psd_pkg::DistMax : sq_q[SqStg].root[psd_pkg::DistW-1:0];
      out_word_q.param_t  <= sq_q[SqStg].t;
      out_word_q.region   <= sq_q[SqStg].region;
    end
  end

endmodule

/* rtl/point_segment_distance_top.sv */
// point_segment_distance_top: top level of the point to segment distance block.
// Depends on psd_pkg, psd_front, psd_queue and psd_back.
//
// Usage
//   Input channel (in_valid_i / in_stall_o / in_word_i): one word holds the
//   query point and the segment's start and end, signed Q12.4 each.
//   Output channel (out_valid_o / out_stall_i / out_word_o): one word per
//   input word, in order: distance (Q13.4, floored), param_t (Q1.16) and region.
//   Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i): writes
//   min_length_squared; always ready. Write it only while the block is empty.
// Throughput: one word per cycle while out_stall_i is low, set by the fully pipelined
//   divider and square root (two result bits per stage each).
// Pipeline: from the accepting input edge to the result word the registers are
//   front stages 2 and 3, the queue write, the divider (load plus 8 steps), the
//   nearest-point and square stages, the square root (load plus 9 steps) and the
//   output register.
// Reset: all pipelines and the queue empty; min_length_squared returns to 1.
// Stall: out_stall_i with a valid output word freezes the back end and holds it; the
//   front keeps taking words until the job queue fills, then raises in_stall_o.

module point_segment_distance_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  psd_pkg::psd_in_t  in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output psd_pkg::psd_out_t out_word_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [psd_pkg::CfgW-1:0] cfg_data_i
);

  logic              push, pop, full, empty;
  psd_pkg::psd_job_t job_in, job_out;

  // front: difference vectors, squared length, dot product, region
  psd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .full_i      (full),
    .push_o      (push),
    .job_o       (job_in)
  );

  // decouples the front from back-end stalls
  psd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .job_o   (job_out)
  );

  // back: t, nearest point, distance
  psd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .job_i       (job_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

/* rtl/psd_checker.sv */
// psd_checker: port-level checks for point_segment_distance_top, and its bind.
// Uses psd_pkg.

module psd_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input psd_pkg::psd_out_t out_word_o
);

  // a stalled result word stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed under stall");

  // start-clamped and degenerate results carry t = 0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.region == psd_pkg::REG_START ||
                    out_word_o.region == psd_pkg::REG_DEGEN)
    |-> out_word_o.param_t == '0)
    else $error("t not zero at start or degenerate");

  // end-clamped results carry t = 1.0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.region == psd_pkg::REG_END
    |-> out_word_o.param_t == psd_pkg::TOne)
    else $error("t not one at end");

  // interior t stays below 1.0 (it may truncate to 0 on long segments)
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.region == psd_pkg::REG_INTERIOR
    |-> out_word_o.param_t < psd_pkg::TOne)
    else $error("interior t out of range");

endmodule

bind point_segment_distance_top psd_checker u_psd_checker (.*);
